// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, muted while in reset
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/srbs_pkg.sv
`timescale 1ns / 1ps
package srbs_pkg;

    localparam int KEY_BYTES = 6;
    localparam int LOC_BYTES = 25;
    localparam int REC_BYTES = 32;
    localparam int REC_SHIFT = 5;
    localparam int KEY_W     = 48;

    typedef enum logic [1:0] {
        STATUS_FOUND      = 2'd0,
        STATUS_NOT_FOUND  = 2'd1,
        STATUS_FORMAT_ERR = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMP_LT = 2'd0,
        CMP_EQ = 2'd1,
        CMP_GT = 2'd2
    } cmp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_LOC_RD,
        ST_LOC_WAIT,
        ST_RES_ERR,
        ST_RES_MISS
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    start;
        logic    probe;
        logic    step;
        logic    loc_rd;
        logic    emit_byte;
        logic    emit_status;
        status_t code;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic table_err;
        logic search_open;
        logic cmp_eq;
        logic out_free;
        logic loc_last;
    } dp_status_t;

    // Byte-wise unsigned compare, most significant first; stops at a shared zero byte
    function automatic cmp_t key_compare(logic [KEY_W-1:0] stored, logic [KEY_W-1:0] wanted);
        cmp_t       res;
        logic       done;
        logic [7:0] a;
        logic [7:0] b;
        res  = CMP_EQ;
        done = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            a = stored[8*(KEY_BYTES-1-i) +: 8];
            b = wanted[8*(KEY_BYTES-1-i) +: 8];
            if (!done)
            begin
                if (a != b)
                begin
                    res  = (a < b) ? CMP_LT : CMP_GT;
                    done = 1'b1;
                end
                else if (a == 8'd0)
                begin
                    done = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/srbs_ram.sv
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port, registered read data
module srbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/srbs_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: accepts items, steps the binary search and paces the result items
module srbs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   mode,
    input  srbs_pkg::dp_status_t   sts,
    output srbs_pkg::ctrl_cmd_t    cmd,
    output logic                   s_tready
);

    srbs_pkg::state_t state_reg;
    srbs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srbs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srbs_pkg::ST_IDLE:
            begin
                if (s_tvalid && mode)
                begin
                    state_next = sts.table_err ? srbs_pkg::ST_RES_ERR : srbs_pkg::ST_PROBE;
                end
            end
            srbs_pkg::ST_PROBE:
            begin
                state_next = sts.search_open ? srbs_pkg::ST_CMP : srbs_pkg::ST_RES_MISS;
            end
            srbs_pkg::ST_CMP:
            begin
                state_next = sts.cmp_eq ? srbs_pkg::ST_LOC_RD : srbs_pkg::ST_PROBE;
            end
            srbs_pkg::ST_LOC_RD:
            begin
                state_next = srbs_pkg::ST_LOC_WAIT;
            end
            srbs_pkg::ST_LOC_WAIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.loc_last ? srbs_pkg::ST_IDLE : srbs_pkg::ST_LOC_RD;
                end
            end
            srbs_pkg::ST_RES_ERR,
            srbs_pkg::ST_RES_MISS:
            begin
                if (sts.out_free)
                begin
                    state_next = srbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srbs_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd          = '0;
        cmd.code     = srbs_pkg::STATUS_NOT_FOUND;
        s_tready     = 1'b0;
        case (state_reg)
            srbs_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.load  = s_tvalid && !mode;
                cmd.start = s_tvalid && mode;
            end
            srbs_pkg::ST_PROBE:
            begin
                cmd.probe = sts.search_open;
            end
            srbs_pkg::ST_CMP:
            begin
                cmd.step = 1'b1;
            end
            srbs_pkg::ST_LOC_RD:
            begin
                cmd.loc_rd = 1'b1;
            end
            srbs_pkg::ST_LOC_WAIT:
            begin
                cmd.emit_byte = sts.out_free;
            end
            srbs_pkg::ST_RES_ERR:
            begin
                cmd.emit_status = sts.out_free;
                cmd.code        = srbs_pkg::STATUS_FORMAT_ERR;
            end
            srbs_pkg::ST_RES_MISS:
            begin
                cmd.emit_status = sts.out_free;
                cmd.code        = srbs_pkg::STATUS_NOT_FOUND;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/srbs_datapath.sv
`timescale 1ns / 1ps
// Record stores, load counters, search bounds, key compare and output register
module srbs_datapath #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  srbs_pkg::ctrl_cmd_t   cmd,
    output srbs_pkg::dp_status_t  sts,
    input  logic [7:0]            file_byte,
    input  logic [srbs_pkg::KEY_W-1:0] search_key,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            location_byte,
    output logic [1:0]            status,
    output logic                  last
);

    localparam int IDX_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int NW        = IDX_W + 1;
    localparam int CAPACITY  = MAX_ENTRIES * srbs_pkg::REC_BYTES;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int LOC_DEPTH = MAX_ENTRIES * srbs_pkg::LOC_BYTES;
    localparam int LADDR_W   = (LOC_DEPTH > 1) ? $clog2(LOC_DEPTH) : 1;
    localparam int LCNT_W    = $clog2(LOC_DEPTH + 1);
    localparam int SH        = srbs_pkg::REC_SHIFT;
    localparam int KW        = srbs_pkg::KEY_W;

    // Load side state
    logic [CNT_W-1:0]  bytes_reg, bytes_next;
    logic              ovf_reg, ovf_next;
    logic [KW-9:0]     key_acc_reg, key_acc_next;
    logic [LCNT_W-1:0] loc_wcnt_reg, loc_wcnt_next;

    // Search side state
    logic [KW-1:0]      key_reg, key_next;
    logic [NW-1:0]      lo_reg, lo_next;
    logic [NW-1:0]      hix_reg, hix_next;
    logic [NW-1:0]      mid_reg, mid_next;
    logic [LADDR_W-1:0] loc_base_reg, loc_base_next;
    logic [4:0]         k_reg, k_next;

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic [1:0] out_status_reg, out_status_next;
    logic       out_last_reg, out_last_next;

    logic [SH-1:0]      pos;
    logic               full;
    logic               key_we;
    logic               loc_we;
    logic [KW-1:0]      key_rd_data;
    logic [7:0]         loc_rd_data;
    logic [NW-1:0]      mid_calc;
    logic [CNT_W-SH-1:0] rec_count;
    logic [LADDR_W-1:0] mid_l;
    srbs_pkg::cmp_t     cmp;

    assign pos       = bytes_reg[SH-1:0];
    assign full      = (bytes_reg == CNT_W'(CAPACITY));
    assign rec_count = bytes_reg[CNT_W-1:SH];
    assign mid_calc  = lo_reg + ((hix_reg - NW'(1) - lo_reg) >> 1);
    assign mid_l     = LADDR_W'(mid_reg);
    assign cmp       = srbs_pkg::key_compare(key_rd_data, key_reg);

    srbs_ram #(
        .WIDTH (KW),
        .DEPTH (MAX_ENTRIES)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_we),
        .wr_addr (bytes_reg[SH +: IDX_W]),
        .wr_data ({key_acc_reg, file_byte}),
        .rd_en   (cmd.probe),
        .rd_addr (mid_calc[IDX_W-1:0]),
        .rd_data (key_rd_data)
    );

    srbs_ram #(
        .WIDTH (8),
        .DEPTH (LOC_DEPTH)
    ) u_loc_ram (
        .clk     (clk),
        .wr_en   (loc_we),
        .wr_addr (loc_wcnt_reg[LADDR_W-1:0]),
        .wr_data (file_byte),
        .rd_en   (cmd.loc_rd),
        .rd_addr (loc_base_reg + LADDR_W'(k_reg)),
        .rd_data (loc_rd_data)
    );

    // Loading: key bytes gather in a shifter, location bytes go straight to the store
    always_comb
    begin
        bytes_next    = bytes_reg;
        ovf_next      = ovf_reg;
        key_acc_next  = key_acc_reg;
        loc_wcnt_next = loc_wcnt_reg;
        key_we        = 1'b0;
        loc_we        = 1'b0;
        if (cmd.load)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                bytes_next = bytes_reg + CNT_W'(1);
                if (pos < SH'(srbs_pkg::KEY_BYTES))
                begin
                    key_acc_next = {key_acc_reg[KW-17:0], file_byte};
                    key_we       = (pos == SH'(srbs_pkg::KEY_BYTES - 1));
                end
                else if (pos < SH'(srbs_pkg::KEY_BYTES + srbs_pkg::LOC_BYTES))
                begin
                    loc_we        = 1'b1;
                    loc_wcnt_next = loc_wcnt_reg + LCNT_W'(1);
                end
            end
        end
    end

    // Search bounds: lo inclusive, hix one past the upper bound
    always_comb
    begin
        key_next      = key_reg;
        lo_next       = lo_reg;
        hix_next      = hix_reg;
        mid_next      = mid_reg;
        loc_base_next = loc_base_reg;
        k_next        = k_reg;
        if (cmd.start)
        begin
            key_next = search_key;
            lo_next  = '0;
            hix_next = NW'(rec_count);
        end
        if (cmd.probe)
        begin
            mid_next = mid_calc;
        end
        if (cmd.step)
        begin
            case (cmp)
                srbs_pkg::CMP_LT:
                begin
                    lo_next = mid_reg + NW'(1);
                end
                srbs_pkg::CMP_GT:
                begin
                    hix_next = mid_reg;
                end
                default:
                begin
                    // mid * 25 by shift and add
                    loc_base_next = (mid_l << 4) + (mid_l << 3) + mid_l;
                    k_next        = '0;
                end
            endcase
        end
        if (cmd.emit_byte)
        begin
            k_next = k_reg + 5'd1;
        end
    end

    // Output register, free when empty or being taken
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_byte_next   = out_byte_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (cmd.emit_byte)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = loc_rd_data;
            out_status_next = srbs_pkg::STATUS_FOUND;
            out_last_next   = (k_reg == 5'(srbs_pkg::LOC_BYTES - 1));
        end
        else if (cmd.emit_status)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = 8'd0;
            out_status_next = cmd.code;
            out_last_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg     <= '0;
            ovf_reg       <= 1'b0;
            loc_wcnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bytes_reg     <= bytes_next;
            ovf_reg       <= ovf_next;
            loc_wcnt_reg  <= loc_wcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_acc_reg    <= key_acc_next;
        key_reg        <= key_next;
        lo_reg         <= lo_next;
        hix_reg        <= hix_next;
        mid_reg        <= mid_next;
        loc_base_reg   <= loc_base_next;
        k_reg          <= k_next;
        out_byte_reg   <= out_byte_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // Status back to the sequencer
    always_comb
    begin
        sts.table_err   = ovf_reg || (pos != '0);
        sts.search_open = (lo_reg < hix_reg);
        sts.cmp_eq      = (cmp == srbs_pkg::CMP_EQ);
        sts.out_free    = !out_valid_reg || m_tready;
        sts.loc_last    = (k_reg == 5'(srbs_pkg::LOC_BYTES - 1));
    end

    assign m_tvalid      = out_valid_reg;
    assign location_byte = out_byte_reg;
    assign status        = out_status_reg;
    assign last          = out_last_reg;

endmodule

// File: rtl/sorted_record_binary_search_core.sv
// Load item: taken in the idle state, no result. Lookup: taken in the idle state, then each
// probe of the key store is a registered read, then a compare, at most floor(log2 N)+1
// probes (11 for 1024 records); a hit then gives 25 items, each read in turn
// through the location store read port, a miss or format error gives one item.
// Reset (rst_n, asynchronous, active low) clears byte counts, overflow flag, sequencer
// and output valid; key and location stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module sorted_record_binary_search_core #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // file_byte [7:0], search_key [55:8]
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // location_byte [7:0]
    output logic [1:0]  m_tuser,   // status [1:0]
    output logic        m_tlast
);

    srbs_pkg::ctrl_cmd_t  cmd;
    srbs_pkg::dp_status_t sts;

    srbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .mode     (s_tuser),
        .sts      (sts),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    srbs_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .file_byte     (s_tdata[7:0]),
        .search_key    (s_tdata[55:8]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .location_byte (m_tdata),
        .status        (m_tuser),
        .last          (m_tlast)
    );

endmodule

// File: rtl/srbs_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Port-level checks on the result stream
module srbs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    logic miss_or_err;
    logic busy_out;

    assign miss_or_err = m_tvalid && (m_tuser != srbs_pkg::STATUS_FOUND);
    assign busy_out    = s_tvalid && s_tready && s_tuser;

    // A pending item stays offered
    `ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    // Not-found and format-error are single, closing items
    `ASSERT_IMPLIES(a_single_last, clk, rst_n, miss_or_err, m_tlast)
    // Only a hit carries location text
    `ASSERT_IMPLIES(a_zero_byte, clk, rst_n, miss_or_err, m_tdata == 8'd0)
    // Status code is never the unused value
    `ASSERT_IMPLIES(a_status_code, clk, rst_n, m_tvalid, m_tuser != 2'd3)
    // A lookup is taken in the idle state and cannot be taken again the next cycle
    `ASSERT_NEXT(a_lookup_busy, clk, rst_n, busy_out, !s_tready)

endmodule

bind sorted_record_binary_search_core srbs_checker u_srbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: dv/tb_sorted_record_binary_search_core.sv
`timescale 1ns / 1ps
module tb_sorted_record_binary_search_core;

    // Small table so that filling it and running past capacity stays short
    localparam int  TABLE_RECS   = 5;
    localparam int  TABLE_BYTES  = TABLE_RECS * srbs_pkg::REC_BYTES;
    localparam int  STALL_LIMIT  = 2000;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  HOLD_LOOKUPS = 8;
    localparam int  DRAIN_CYCLES = 100;
    localparam int  RAND_OPS     = 28;
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;
    localparam logic [47:0] KEY_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        srbs_pkg::status_t status;
        logic [7:0]        loc;
        logic              last;
    } reply_t;

    typedef enum logic {ROW_LOOKUP, ROW_RECORD} row_kind_t;

    // One row of the directed script: a lookup, or some bytes of a record
    typedef struct {
        row_kind_t         kind;
        logic [47:0]       key;
        logic [7:0]        seed;
        int                nbytes;
        logic              typed;
        srbs_pkg::status_t typed_status;
    } script_row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;   // file_byte [7:0], search_key [55:8]
    logic        s_tuser  = 1'b0; // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // location_byte [7:0]
    logic [1:0]  m_tuser;         // status [1:0]
    logic        m_tlast;

    // Shadow copy of the record table
    logic [47:0] tab_keys [0:TABLE_RECS-1];
    logic [7:0]  tab_locs [0:TABLE_RECS*srbs_pkg::LOC_BYTES-1];
    int          tab_bytes = 0;
    logic        tab_over  = 1'b0;

    reply_t      pending_replies[$];
    logic [47:0] loaded_keys[$];
    logic [7:0]  rec_buf [0:srbs_pkg::REC_BYTES-1];
    logic [47:0] rec_key;
    int          errors        = 0;
    int          src_idle_pct  = 31;
    int          sink_idle_pct = 78;
    logic        hold_req      = 1'b0;

    sorted_record_binary_search_core #(
        .MAX_ENTRIES(TABLE_RECS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Byte-wise ordering, first byte most significant, ends at a zero byte both share
    function automatic int key_order(logic [47:0] stored, logic [47:0] wanted);
        logic [7:0] a;
        logic [7:0] b;
        for (int i = 0; i < srbs_pkg::KEY_BYTES; i++)
        begin
            a = stored[47-8*i -: 8];
            b = wanted[47-8*i -: 8];
            if (a != b)
                return (a < b) ? -1 : 1;
            if (a == 8'd0)
                return 0;
        end
        return 0;
    endfunction

    function automatic logic [47:0] rand_key();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    task automatic table_load_byte(logic [7:0] b);
        int rec;
        int pos;
        if (tab_bytes >= TABLE_BYTES)
        begin
            tab_over = 1'b1;
            return;
        end
        rec = tab_bytes / srbs_pkg::REC_BYTES;
        pos = tab_bytes % srbs_pkg::REC_BYTES;
        if (pos == 0)
            tab_keys[rec] = {40'd0, b};
        else if (pos < srbs_pkg::KEY_BYTES)
            tab_keys[rec] = {tab_keys[rec][39:0], b};
        else if (pos < srbs_pkg::KEY_BYTES + srbs_pkg::LOC_BYTES)
            tab_locs[rec*srbs_pkg::LOC_BYTES + pos - srbs_pkg::KEY_BYTES] = b;
        tab_bytes++;
    endtask

    // Binary search over complete records; queues the results the lookup gives
    task automatic table_lookup(logic [47:0] key);
        int lo;
        int hi;
        int mid;
        int c;
        if (tab_over || (tab_bytes % srbs_pkg::REC_BYTES) != 0)
        begin
            pending_replies.push_back('{srbs_pkg::STATUS_FORMAT_ERR, 8'h00, 1'b1});
            return;
        end
        lo = 0;
        hi = tab_bytes / srbs_pkg::REC_BYTES - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            c   = key_order(tab_keys[mid], key);
            if (c == 0)
            begin
                for (int k = 0; k < srbs_pkg::LOC_BYTES; k++)
                    pending_replies.push_back('{srbs_pkg::STATUS_FOUND,
                                                tab_locs[mid*srbs_pkg::LOC_BYTES + k],
                                                k == srbs_pkg::LOC_BYTES - 1});
                return;
            end
            if (c < 0)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        pending_replies.push_back('{srbs_pkg::STATUS_NOT_FOUND, 8'h00, 1'b1});
    endtask

    // Offer one item, with random idle cycles ahead of it; predict once accepted
    task automatic send_item(logic mode, logic [7:0] fbyte, logic [47:0] key,
                             logic typed, srbs_pkg::status_t typed_status);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {key, fbyte};
        do
            @(posedge clk);
        while (!s_tready);
        if (typed)
            pending_replies.push_back('{typed_status, 8'h00, 1'b1});
        else if (mode == MODE_LOAD)
            table_load_byte(fbyte);
        else
            table_lookup(key);
    endtask

    task automatic send_load(logic [7:0] b);
        send_item(MODE_LOAD, b, rand_key(), 1'b0, srbs_pkg::STATUS_FOUND);
    endtask

    task automatic send_lookup(logic [47:0] k);
        send_item(MODE_LOOKUP, 8'($urandom), k, 1'b0, srbs_pkg::STATUS_FOUND);
    endtask

    // Record image: key, location text (pattern or random), separator
    task automatic fill_record_buf(logic [47:0] key, logic [7:0] seed, logic rand_locs);
        rec_key = key;
        for (int p = 0; p < srbs_pkg::KEY_BYTES; p++)
            rec_buf[p] = key[47-8*p -: 8];
        for (int i = 0; i < srbs_pkg::LOC_BYTES; i++)
            rec_buf[srbs_pkg::KEY_BYTES+i] = rand_locs ? 8'($urandom) : 8'(seed + i * 41);
        rec_buf[srbs_pkg::REC_BYTES-1] =
            (rand_locs && $urandom_range(3) == 0) ? 8'($urandom) : 8'h0A;
    endtask

    // Send the next n bytes of the record in rec_buf, from where the table stands
    task automatic send_record_part(int n);
        int pos;
        for (int i = 0; i < n; i++)
        begin
            pos = tab_bytes % srbs_pkg::REC_BYTES;
            send_load(rec_buf[pos]);
            if (pos == srbs_pkg::REC_BYTES - 1)
                loaded_keys.push_back(rec_key);
        end
    endtask

    function automatic logic [47:0] pick_stored();
        return loaded_keys[$urandom_range(loaded_keys.size() - 1)];
    endfunction

    // Result side: random back-pressure, one long hold-off on request, checking
    initial
    begin
        reply_t exp;
        int     hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $display("%0t: result with none expected: status %0d byte %02h last %0b",
                             $time, m_tuser, m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    exp = pending_replies.pop_front();
                    if (m_tuser !== exp.status)
                    begin
                        $display("%0t: status expected %0d got %0d", $time, exp.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata !== exp.loc)
                    begin
                        $display("%0t: location byte expected %02h got %02h",
                                 $time, exp.loc, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== exp.last)
                    begin
                        $display("%0t: last expected %0b got %0b", $time, exp.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog: cycles in a row with no item taken on either side
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus
    initial
    begin
        script_row_t script [22];
        logic [47:0] key;
        int          r;

        // empty table, record at the lowest key, partial record, shared zero bytes,
        // high keys, then a one-byte partial record; the last record row fills the table
        script[0]  = '{ROW_LOOKUP, 48'h0,              8'h00, 0,  1'b1,
                       srbs_pkg::STATUS_NOT_FOUND};
        script[1]  = '{ROW_LOOKUP, KEY_MAX,            8'h00, 0,  1'b1,
                       srbs_pkg::STATUS_NOT_FOUND};
        script[2]  = '{ROW_RECORD, 48'h0,              8'h00, 32, 1'b0, srbs_pkg::STATUS_FOUND};
        script[3]  = '{ROW_LOOKUP, 48'h0,              8'h00, 0,  1'b0, srbs_pkg::STATUS_FOUND};
        script[4]  = '{ROW_LOOKUP, 48'h00FF_FFFF_FFFF, 8'h00, 0,  1'b0, srbs_pkg::STATUS_FOUND};
        script[5]  = '{ROW_RECORD, 48'h4142_0000_0000, 8'hFF, 3,  1'b0, srbs_pkg::STATUS_FOUND};
        script[6]  = '{ROW_LOOKUP, 48'h4142_0000_0000, 8'h00, 0,  1'b1,
                       srbs_pkg::STATUS_FORMAT_ERR};
        script[7]  = '{ROW_RECORD, 48'h4142_0000_0000, 8'hFF, 29, 1'b0, srbs_pkg::STATUS_FOUND};
        script[8]  = '{ROW_LOOKUP, 48'h4142_0000_0000, 8'h00, 0,  1'b0, srbs_pkg::STATUS_FOUND};
        script[9]  = '{ROW_LOOKUP, 48'h4142_0000_FF00, 8'h00, 0,  1'b0, srbs_pkg::STATUS_FOUND};
        script[10] = '{ROW_LOOKUP, 48'h4143_0000_0000, 8'h00, 0,  1'b0, srbs_pkg::STATUS_FOUND};
        script[11] = '{ROW_RECORD, 48'h7F80_01FE_0102, 8'h5A, 32, 1'b0, srbs_pkg::STATUS_FOUND};
        script[12] = '{ROW_RECORD, 48'h80FF_7F01_FE55, 8'hA5, 32, 1'b0, srbs_pkg::STATUS_FOUND};
        script[13] = '{ROW_LOOKUP, 48'h7F80_01FE_0102, 8'h00, 0,  1'b0, srbs_pkg::STATUS_FOUND};
        script[14] = '{ROW_LOOKUP, 48'h80FF_7F01_FE55, 8'h00, 0,  1'b0, srbs_pkg::STATUS_FOUND};
        script[15] = '{ROW_LOOKUP, 48'h80FF_7F01_FE54, 8'h00, 0,  1'b0, srbs_pkg::STATUS_FOUND};
        script[16] = '{ROW_LOOKUP, KEY_MAX,            8'h00, 0,  1'b0, srbs_pkg::STATUS_FOUND};
        script[17] = '{ROW_LOOKUP, 48'h0000_0000_0001, 8'h00, 0,  1'b0, srbs_pkg::STATUS_FOUND};
        script[18] = '{ROW_RECORD, 48'h8123_4567_ABCD, 8'h33, 1,  1'b0, srbs_pkg::STATUS_FOUND};
        script[19] = '{ROW_LOOKUP, 48'h8123_4567_ABCD, 8'h00, 0,  1'b1,
                       srbs_pkg::STATUS_FORMAT_ERR};
        script[20] = '{ROW_RECORD, 48'h8123_4567_ABCD, 8'h33, 31, 1'b0, srbs_pkg::STATUS_FOUND};
        script[21] = '{ROW_LOOKUP, 48'h8123_4567_ABCD, 8'h00, 0,  1'b0, srbs_pkg::STATUS_FOUND};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        foreach (script[i])
        begin
            if (script[i].kind == ROW_RECORD)
            begin
                if (tab_bytes % srbs_pkg::REC_BYTES == 0)
                    fill_record_buf(script[i].key, script[i].seed, 1'b0);
                send_record_part(script[i].nbytes);
            end
            else
                send_item(MODE_LOOKUP, 8'($urandom), script[i].key,
                          script[i].typed, script[i].typed_status);
        end

        // Random part: lookups of stored, near-miss, random and shortened keys
        for (int op = 0; op < RAND_OPS; op++)
        begin
            if (op == RAND_OPS / 2)
            begin
                src_idle_pct  = 78;
                sink_idle_pct = 31;
                // long receiver hold-off while hits keep coming
                hold_req = 1'b1;
                repeat (HOLD_LOOKUPS) send_lookup(pick_stored());
            end
            r   = $urandom_range(99);
            key = pick_stored();
            if (r < 45)
                send_lookup(key);
            else if (r < 65)
                send_lookup(key ^ (48'd1 << $urandom_range(47)));
            else if (r < 85)
                send_lookup(rand_key());
            else
                send_lookup(key & ~((48'd1 << (8 * $urandom_range(1, 5))) - 48'd1));
        end

        // Searches on the full table, no idling on either side
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_lookup(48'h0);
        send_lookup(KEY_MAX);
        send_lookup(KEY_MAX - 48'd1);
        repeat (3) send_lookup(pick_stored());
        repeat (2) send_lookup(rand_key());

        // Byte past capacity: dropped, table marked unusable
        send_load(8'h0A);
        send_lookup(KEY_MAX);
        send_load(8'($urandom));
        send_lookup(pick_stored());
        s_tvalid <= 1'b0;

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sorted_record_binary_search_core.f
+incdir+rtl
rtl/srbs_pkg.sv
rtl/srbs_ram.sv
rtl/srbs_ctrl.sv
rtl/srbs_datapath.sv
rtl/sorted_record_binary_search_core.sv
rtl/srbs_checker.sv
dv/tb_sorted_record_binary_search_core.sv
